>>> src/cbad_pkg.sv
// ----------------------------------------------------------------------------
// cbad_pkg
// Shared codes and defaults for the CPU bus address decoder: request modes,
// target and status codes, bus map boundaries, sequencer states and read-data selects.
// ----------------------------------------------------------------------------
package cbad_pkg;

   // default memory sizes
   localparam int DEF_RAM_BYTES = 2048;
   localparam int DEF_ROM_BYTES = 32768;

   // request modes
   localparam logic [2:0] MODE_READ_BYTE  = 3'd0;
   localparam logic [2:0] MODE_WRITE_BYTE = 3'd1;
   localparam logic [2:0] MODE_READ_WORD  = 3'd2;
   localparam logic [2:0] MODE_WRITE_WORD = 3'd3;
   localparam logic [2:0] MODE_LOAD_ROM   = 3'd4;

   // target codes
   localparam logic [2:0] TGT_NONE     = 3'd0;
   localparam logic [2:0] TGT_RAM      = 3'd1;
   localparam logic [2:0] TGT_PPU      = 3'd2;
   localparam logic [2:0] TGT_PAD      = 3'd3;
   localparam logic [2:0] TGT_ROM      = 3'd4;
   localparam logic [2:0] TGT_DMA      = 3'd5;
   localparam logic [2:0] TGT_APU      = 3'd6;
   localparam logic [2:0] TGT_UNMAPPED = 3'd7;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_ROM_WRITE = 2'd1;
   localparam logic [1:0] STAT_UNMAPPED  = 2'd2;
   localparam logic [1:0] STAT_NO_WORD   = 2'd3;

   // bus map boundaries
   localparam logic [15:0] ADDR_PPU_BASE  = 16'h2000;
   localparam logic [15:0] ADDR_IO_BASE   = 16'h4000;
   localparam logic [15:0] ADDR_OAM_DMA   = 16'h4014;
   localparam logic [15:0] ADDR_PAD0      = 16'h4016;
   localparam logic [15:0] ADDR_PAD1      = 16'h4017;
   localparam logic [15:0] ADDR_CART_BASE = 16'h4020;
   localparam logic [15:0] ADDR_LAST      = 16'hFFFF;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_DECODE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // how read data is assembled at the end of a request
   typedef enum logic [2:0] {
      RD_NONE,
      RD_RAM_BYTE,
      RD_RAM_WORD,
      RD_ROM_BYTE,
      RD_ROM_WORD
   } rdsel_type;

endpackage

>>> src/cpu_bus_address_decoder.sv
// Each request passes through acceptance (the RAM mirror offset is
// multiplied by a reciprocal here), decode with the memory access (both RAM
// and ROM have two registered read ports, so a word read needs one pass), and
// a finish cycle that assembles the read data, writes the high byte of a word
// write and presents the response in the following cycle. A new request is
// taken in the cycle the previous response is accepted; a stalled response
// holds off new requests, and none is taken before the previous one is through
// decode and finish. After reset the work RAM is cleared one byte per cycle,
// all RAM_BYTES bytes, with req_stall held high; csr writes are taken throughout.
// ----------------------------------------------------------------------------
// cpu_bus_address_decoder
// Decodes 16-bit CPU bus accesses onto mirrored work RAM, program ROM and
// forwarded register targets, with a ROM load path.
// ----------------------------------------------------------------------------
module cpu_bus_address_decoder #(
   parameter int RAM_BYTES = cbad_pkg::DEF_RAM_BYTES,
   parameter int ROM_BYTES = cbad_pkg::DEF_ROM_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_address,
   input  logic [15:0] req_write_data,
   input  logic        req_wrap_page,
   input  logic [14:0] req_rom_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic [2:0]  rsp_target,
   output logic [2:0]  rsp_ppu_register,
   output logic        rsp_joypad_port,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import cbad_pkg::*;

   localparam int RAM_AW    = $clog2(RAM_BYTES);
   localparam int ROM_AW    = $clog2(ROM_BYTES);
   // floor(a / RAM_BYTES) = (a * RECIP) >> MOD_SHIFT, exact for a < 8192
   localparam int MOD_SHIFT = 26;
   localparam int RECIP     = (2 ** MOD_SHIFT + RAM_BYTES - 1) / RAM_BYTES;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = 13 + RECIP_W;
   localparam int Q_W       = PROD_W - MOD_SHIFT;
   localparam logic [RAM_AW:0]   RAM_LIM  = (RAM_AW + 1)'(RAM_BYTES);
   localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(RAM_BYTES - 1);

   // ROM index from a 15-bit offset, with 16 KB mirroring
   function automatic logic [ROM_AW-1:0] rom_index(input logic [14:0] off,
                                                   input logic half_mode);
      logic [15:0] o;
      o = half_mode ? {2'b00, off[13:0]} : {1'b0, off};
      if (o >= 16'(ROM_BYTES)) o = o - 16'(ROM_BYTES);
      return o[ROM_AW-1:0];
   endfunction

   // control state
   state_type         state_ff, state_in;
   logic [RAM_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              prg_is_16k_ff, prg_is_16k_in;

   // captured request
   logic [2:0]        mode_ff;
   logic [15:0]       addr_ff;
   logic [15:0]       wdata_ff;
   logic              wrap_ff;
   logic [14:0]       roff_ff;
   logic [PROD_W-1:0] prod_ff;

   // decode results carried into the finish cycle
   rdsel_type         rd_sel_ff, rd_sel_in;
   logic              hi_write_ff, hi_write_in;
   logic              rom_hi_zero_ff, rom_hi_zero_in;
   logic [RAM_AW-1:0] ram_hi_ff;

   // response payload
   logic [15:0] rsp_read_data_ff;
   logic [2:0]  rsp_target_ff, rsp_target_in;
   logic [2:0]  rsp_ppu_register_ff, rsp_ppu_register_in;
   logic        rsp_joypad_port_ff, rsp_joypad_port_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] read_data_in;

   // memories
   logic [7:0]        ram_mem [RAM_BYTES];
   logic [7:0]        rom_mem [ROM_BYTES];
   logic [7:0]        ram_q0_ff, ram_q1_ff, rom_q0_ff, rom_q1_ff;
   logic              ram_we, rom_we;
   logic [RAM_AW-1:0] ram_wa, ram_ra0, ram_ra1;
   logic [7:0]        ram_wd;
   logic [ROM_AW-1:0] rom_wa, rom_ra0, rom_ra1;

   // decode datapath
   logic              req_accept;
   logic [Q_W-1:0]    quot;
   logic [13:0]       quot_x_ram, ram_lo_full;
   logic [RAM_AW-1:0] ram_lo;
   logic [RAM_AW:0]   ram_lo_ext, ram_inc, ram_pw, ram_hi_ext;
   logic [15:0]       rom_hi_addr;
   logic              in_ram, in_ppu, below_cart, in_io;

   // handshake
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   // RAM index = address mod RAM_BYTES
   assign quot        = prod_ff[PROD_W-1:MOD_SHIFT];
   assign quot_x_ram  = 14'(quot * RAM_BYTES);
   assign ram_lo_full = {1'b0, addr_ff[12:0]} - quot_x_ram;
   assign ram_lo      = ram_lo_full[RAM_AW-1:0];

   // RAM high byte index, reduced mod RAM_BYTES; page wrap on word reads only
   always_comb begin
      ram_lo_ext = {1'b0, ram_lo};
      ram_inc    = ram_lo_ext + 1'b1;
      ram_pw     = {ram_lo_ext[RAM_AW:8], ram_inc[7:0]};
      if (wrap_ff && (mode_ff == MODE_READ_WORD)) begin
         ram_hi_ext = (ram_pw >= RAM_LIM) ? ram_pw - RAM_LIM : ram_pw;
      end else begin
         ram_hi_ext = (ram_inc == RAM_LIM) ? '0 : ram_inc;
      end
   end

   // ROM high byte address
   assign rom_hi_addr    = wrap_ff ? {addr_ff[15:8], addr_ff[7:0] + 8'd1}
                                   : addr_ff + 16'd1;
   assign rom_hi_zero_in = !wrap_ff && (addr_ff == ADDR_LAST);

   // region flags
   assign in_ram     = addr_ff < ADDR_PPU_BASE;
   assign in_ppu     = !in_ram && (addr_ff < ADDR_IO_BASE);
   assign below_cart = addr_ff < ADDR_CART_BASE;
   assign in_io      = !in_ram && !in_ppu && below_cart;

   // request decode
   always_comb begin
      rsp_target_in       = TGT_NONE;
      rsp_ppu_register_in = 3'd0;
      rsp_joypad_port_in  = 1'b0;
      rsp_status_in       = STAT_OK;
      rd_sel_in           = RD_NONE;
      hi_write_in         = 1'b0;
      case (mode_ff)
         MODE_READ_BYTE: begin
            if (in_ram) begin
               rsp_target_in = TGT_RAM;
               rd_sel_in     = RD_RAM_BYTE;
            end else if (in_ppu) begin
               rsp_target_in       = TGT_PPU;
               rsp_ppu_register_in = addr_ff[2:0];
            end else if (addr_ff == ADDR_PAD0 || addr_ff == ADDR_PAD1) begin
               rsp_target_in      = TGT_PAD;
               rsp_joypad_port_in = addr_ff[0];
            end else if (addr_ff[15]) begin
               rsp_target_in = TGT_ROM;
               rd_sel_in     = RD_ROM_BYTE;
            end else if (in_io) begin
               rsp_target_in = TGT_APU;
            end else begin
               rsp_target_in = TGT_UNMAPPED;
            end
         end
         MODE_WRITE_BYTE: begin
            if (in_ram) begin
               rsp_target_in = TGT_RAM;
            end else if (in_ppu) begin
               rsp_target_in       = TGT_PPU;
               rsp_ppu_register_in = addr_ff[2:0];
            end else if (addr_ff == ADDR_OAM_DMA) begin
               rsp_target_in = TGT_DMA;
            end else if (addr_ff[15]) begin
               rsp_target_in = TGT_ROM;
               rsp_status_in = STAT_ROM_WRITE;
            end else if (addr_ff == ADDR_PAD0) begin
               rsp_target_in = TGT_PAD;
            end else if (in_io) begin
               rsp_target_in = TGT_APU;
            end else begin
               rsp_target_in = TGT_UNMAPPED;
               rsp_status_in = STAT_UNMAPPED;
            end
         end
         MODE_READ_WORD: begin
            if (in_ram) begin
               rsp_target_in = TGT_RAM;
               rd_sel_in     = RD_RAM_WORD;
            end else if (in_ppu) begin
               rsp_target_in       = TGT_PPU;
               rsp_ppu_register_in = addr_ff[2:0];
               rsp_status_in       = STAT_NO_WORD;
            end else if (!addr_ff[15]) begin
               rsp_target_in = TGT_UNMAPPED;
            end else begin
               rsp_target_in = TGT_ROM;
               rd_sel_in     = RD_ROM_WORD;
            end
         end
         MODE_WRITE_WORD: begin
            if (in_ram) begin
               rsp_target_in = TGT_RAM;
               hi_write_in   = 1'b1;
            end else begin
               rsp_status_in = STAT_NO_WORD;
            end
         end
         default: begin
         end
      endcase
   end

   // memory port control
   always_comb begin
      ram_we  = 1'b0;
      ram_wa  = ram_lo;
      ram_wd  = wdata_ff[7:0];
      ram_ra0 = ram_lo;
      ram_ra1 = ram_hi_ext[RAM_AW-1:0];
      rom_we  = (state_ff == ST_DECODE) && (mode_ff == MODE_LOAD_ROM);
      rom_wa  = rom_index(roff_ff, 1'b0);
      rom_ra0 = rom_index(addr_ff[14:0], prg_is_16k_ff);
      rom_ra1 = rom_index(rom_hi_addr[14:0], prg_is_16k_ff);
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_cnt_ff;
            ram_wd = 8'h00;
         end
         ST_DECODE: begin
            ram_we = in_ram && (mode_ff == MODE_WRITE_BYTE ||
                                mode_ff == MODE_WRITE_WORD);
         end
         ST_FINISH: begin
            ram_we = hi_write_ff;
            ram_wa = ram_hi_ff;
            ram_wd = wdata_ff[15:8];
         end
         default: begin
         end
      endcase
   end

   // read data assembly
   always_comb begin
      case (rd_sel_ff)
         RD_RAM_BYTE: read_data_in = {8'h00, ram_q0_ff};
         RD_RAM_WORD: read_data_in = {ram_q1_ff, ram_q0_ff};
         RD_ROM_BYTE: read_data_in = {8'h00, rom_q0_ff};
         RD_ROM_WORD: read_data_in = {rom_hi_zero_ff ? 8'h00 : rom_q1_ff, rom_q0_ff};
         default:     read_data_in = 16'h0000;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      prg_is_16k_in = csr_write_enable ? csr_write_data : prg_is_16k_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == RAM_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         prg_is_16k_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         prg_is_16k_ff <= prg_is_16k_in;
      end
   end

   // request capture and modulo product
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= req_mode;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
         wrap_ff  <= req_wrap_page;
         roff_ff  <= req_rom_offset;
         prod_ff  <= PROD_W'(req_address[12:0]) * PROD_W'(RECIP);
      end
   end

   // decode results and response payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_DECODE) begin
         rd_sel_ff           <= rd_sel_in;
         hi_write_ff         <= hi_write_in;
         rom_hi_zero_ff      <= rom_hi_zero_in;
         ram_hi_ff           <= ram_hi_ext[RAM_AW-1:0];
         rsp_target_ff       <= rsp_target_in;
         rsp_ppu_register_ff <= rsp_ppu_register_in;
         rsp_joypad_port_ff  <= rsp_joypad_port_in;
         rsp_status_ff       <= rsp_status_in;
      end
      if (state_ff == ST_FINISH) begin
         rsp_read_data_ff <= read_data_in;
      end
   end

   // work RAM: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (ram_we) ram_mem[ram_wa] <= ram_wd;
      ram_q0_ff <= ram_mem[ram_ra0];
      ram_q1_ff <= ram_mem[ram_ra1];
   end

   // program ROM: load port, two registered read ports
   always_ff @(posedge clock) begin
      if (rom_we) rom_mem[rom_wa] <= wdata_ff[7:0];
      rom_q0_ff <= rom_mem[rom_ra0];
      rom_q1_ff <= rom_mem[rom_ra1];
   end

   // outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_target       = rsp_target_ff;
   assign rsp_ppu_register = rsp_ppu_register_ff;
   assign rsp_joypad_port  = rsp_joypad_port_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
